// ----- design/sample_condition_matcher_core_assert.svh -----
// Assertion macros for the matcher; scm_merge includes them.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef SAMPLE_CONDITION_MATCHER_CORE_ASSERT_SVH
`define SAMPLE_CONDITION_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication.
`define SCM_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication.
`define SCM_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ----- design/scm_pkg.sv -----
`timescale 1ns / 1ps

package scm_pkg;

	// Field and register widths.
	localparam int DEF_CHANNELS = 16;
	localparam int SAMPLE_W     = 16;
	localparam int INDEX_W      = 64;
	localparam int NUM_CONDS    = 3;
	localparam int MASK_W       = NUM_CONDS;
	localparam int TERM_W       = 3;
	localparam int SKIP_W       = 32;
	localparam int ACTIVE_W     = 2;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 48;
	localparam int M_TDATA_W    = 72;

	// Channel term codes.
	localparam logic [TERM_W-1:0] TERM_NONE = 3'd0;
	localparam logic [TERM_W-1:0] TERM_HIGH = 3'd1;
	localparam logic [TERM_W-1:0] TERM_LOW  = 3'd2;
	localparam logic [TERM_W-1:0] TERM_RISE = 3'd3;
	localparam logic [TERM_W-1:0] TERM_FALL = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMS_A = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMS_B = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMS_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_A  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_B  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_C  = 3'd6;

	// Per-lane control from the top level.
	typedef struct packed {
		logic step;
		logic clear;
	} lane_ctl_t;

	// What the lanes hand to the merging stage for one word.
	typedef struct packed {
		logic              accept;
		logic              none_active;
		logic [MASK_W-1:0] hits;
	} merge_in_t;

	// One channel term against the current and previous level.
	// Unused codes behave as don't-care.
	function automatic logic term_ok(logic [TERM_W-1:0] code, logic now, logic was);
		logic ok;
		case (code)
			TERM_HIGH: ok = now;
			TERM_LOW:  ok = !now;
			TERM_RISE: ok = !was && now;
			TERM_FALL: ok = was && !now;
			default:   ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

// ----- design/sample_condition_matcher_core.sv -----
`timescale 1ns / 1ps
// Trigger condition matcher for a multi-channel logic sample stream.
// Slave channel s_*: one sample word per transfer, bit n of s_tdata is channel n.
// Master channel m_*: one result word for each sample on which a condition held,
// or for every sample when no condition is active.
// Configuration channel cfg_*: cfg_index selects the register (0 active count,
// 1..3 channel terms of conditions a..c, 4..6 skip targets), cfg_data the value.
// cfg_ready is always high; any write to a listed register restarts all skip counts.
// Three condition lanes evaluate each sample in parallel; the merging stage
// combines their hits into the mask and registers the result.
// Throughput: one sample per cycle while the receiver keeps up. The result word is valid
// the cycle after its sample is accepted, held in the single output register.
// When the receiver stalls with a result pending, s_tready drops until the
// result is taken; samples with no match never occupy the output register.
// Reset clears the registers, the previous sample, the sample counter and the
// skip counters, and empties the output register.
module sample_condition_matcher_core import scm_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// s_tdata: sample_bits[15:0]
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,
	// m_tdata: sample_index[63:0], match_mask[66:64], zero fill[71:67]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_TDATA_W-1:0]  m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int TERMS_W = TERM_W * CHANNELS;

	logic [ACTIVE_W-1:0] active_q;
	logic [TERMS_W-1:0]  terms_q  [NUM_CONDS];
	logic [SKIP_W-1:0]   target_q [NUM_CONDS];
	logic [CHANNELS-1:0] prev_q;
	logic [CHANNELS-1:0] cur;
	logic                cfg_we;
	logic                cfg_hit;
	logic                accept;
	logic [MASK_W-1:0]   active_vec;
	logic [MASK_W-1:0]   lane_hit;
	lane_ctl_t           lane_ctl [NUM_CONDS];
	merge_in_t           mi;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign accept    = s_tvalid && s_tready;
	assign cur       = s_tdata[CHANNELS-1:0];

	// Register index decode; indexes beyond the list leave everything alone.
	always_comb begin
		unique case (cfg_index) inside
			CFG_ACTIVE, CFG_TERMS_A, CFG_TERMS_B, CFG_TERMS_C,
			CFG_SKIP_A, CFG_SKIP_B, CFG_SKIP_C: cfg_hit = 1'b1;
			default:                            cfg_hit = 1'b0;
		endcase
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int k = 0; k < NUM_CONDS; k++) begin
				terms_q[k]  <= '0;
				target_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE:  active_q    <= cfg_data[ACTIVE_W-1:0];
				CFG_TERMS_A: terms_q[0]  <= cfg_data[TERMS_W-1:0];
				CFG_TERMS_B: terms_q[1]  <= cfg_data[TERMS_W-1:0];
				CFG_TERMS_C: terms_q[2]  <= cfg_data[TERMS_W-1:0];
				CFG_SKIP_A:  target_q[0] <= cfg_data[SKIP_W-1:0];
				CFG_SKIP_B:  target_q[1] <= cfg_data[SKIP_W-1:0];
				CFG_SKIP_C:  target_q[2] <= cfg_data[SKIP_W-1:0];
				default:     ;
			endcase
		end
	end

	// Previous sample for the edge terms.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (accept) begin
			prev_q <= cur;
		end
	end

	// Condition lanes; only lanes below the active count take part.
	for (genvar k = 0; k < NUM_CONDS; k++) begin : g_lane
		assign active_vec[k]      = ACTIVE_W'(k) < active_q;
		assign lane_ctl[k].step   = accept && active_vec[k];
		assign lane_ctl[k].clear  = cfg_we && cfg_hit;

		scm_lane #(
			.CHANNELS (CHANNELS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (lane_ctl[k]),
			.cur    (cur),
			.prev   (prev_q),
			.terms  (terms_q[k]),
			.target (target_q[k]),
			.hit    (lane_hit[k])
		);
	end

	// Merge lane hits into the result word.
	assign mi.accept      = accept;
	assign mi.none_active = active_q == '0;
	assign mi.hits        = lane_hit & active_vec;

	scm_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.mi       (mi),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- design/scm_lane.sv -----
`timescale 1ns / 1ps

module scm_lane import scm_pkg::*; #(
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lane_ctl_t                  ctl,
	input  logic [CHANNELS-1:0]        cur,
	input  logic [CHANNELS-1:0]        prev,
	input  logic [TERM_W*CHANNELS-1:0] terms,
	input  logic [SKIP_W-1:0]          target,
	output logic                       hit
);

	logic [SKIP_W-1:0] skipped_q;
	logic              skipping;
	logic              terms_match;

	assign skipping = skipped_q < target;

	// Skip counter: cleared by any write to a listed register, advanced while skipping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skipped_q <= '0;
		end else if (ctl.clear) begin
			skipped_q <= '0;
		end else if (ctl.step && skipping) begin
			skipped_q <= skipped_q + 1'b1;
		end
	end

	// AND of all channel terms.
	always_comb begin
		terms_match = 1'b1;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			terms_match &= term_ok(terms[TERM_W*ch +: TERM_W], cur[ch], prev[ch]);
		end
	end

	assign hit = !skipping && terms_match;

endmodule

// ----- design/scm_merge.sv -----
`timescale 1ns / 1ps

module scm_merge import scm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  merge_in_t            mi,
	output logic                 in_ready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

`include "sample_condition_matcher_core_assert.svh"

	logic [INDEX_W-1:0] count_q;
	logic               valid_q;
	logic [INDEX_W-1:0] index_q;
	logic [MASK_W-1:0]  mask_q;
	logic               found;

	// A word yields a result when no condition is in use or any lane hit.
	assign found    = mi.none_active || (|mi.hits);
	assign in_ready = !valid_q || m_tready;

	// Sample counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (mi.accept) begin
				count_q <= count_q + 1'b1;
				valid_q <= found;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (mi.accept && found) begin
			index_q <= count_q;
			mask_q  <= mi.hits;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(M_TDATA_W - INDEX_W - MASK_W){1'b0}}, mask_q, index_q};

	`SCM_ASSERT_NEXT(a_found_valid, mi.accept && found, valid_q, "matching word gave no result")
	`SCM_ASSERT_NEXT(a_index, mi.accept && found, index_q == $past(count_q), "wrong sample index")
	`SCM_ASSERT_NEXT(a_count, mi.accept, count_q == $past(count_q) + 1'b1, "counter did not step")
	`SCM_ASSERT_NOW(a_stall, valid_q && !m_tready, !in_ready, "input taken over stalled result")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import scm_pkg::*;

	// Index past the register list; a write there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNLISTED = 3'd7;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS = 150;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic [MASK_W-1:0]  mask;
	} match_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [SAMPLE_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	sample_condition_matcher_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the matcher registers and state.
	logic [ACTIVE_W-1:0]   active_count = '0;
	logic [CFG_DATA_W-1:0] cond_terms[NUM_CONDS] = '{default: '0};
	logic [SKIP_W-1:0]     skip_target[NUM_CONDS] = '{default: '0};
	logic [SKIP_W-1:0]     skip_done[NUM_CONDS] = '{default: '0};
	logic [SAMPLE_W-1:0]   prev_sample = '0;
	logic [INDEX_W-1:0]    sample_no = '0;

	logic [SAMPLE_W-1:0] sample_q[$];
	match_t expected_matches[$];
	logic [SAMPLE_W-1:0] last_pushed = '0;

	int mismatches = 0;
	int cycle_count = 0;
	int send_wait = 0;
	int recv_wait = 0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	bit pressure_go = 1'b0;
	logic long_hold = 1'b0;

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int draw_wait(bit enabled);
		if (!enabled)
			return 0;
		return ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 17)) : 0;
	endfunction

	// True when every channel term of one condition holds for this sample.
	function automatic bit cond_holds(logic [CFG_DATA_W-1:0] terms,
			logic [SAMPLE_W-1:0] now_s, logic [SAMPLE_W-1:0] was_s);
		logic [TERM_W-1:0] code;
		bit ok;
		ok = 1'b1;
		for (int ch = 0; ch < DEF_CHANNELS; ch++) begin
			code = terms[TERM_W*ch +: TERM_W];
			case (code)
				TERM_HIGH: if (!now_s[ch]) ok = 1'b0;
				TERM_LOW:  if (now_s[ch]) ok = 1'b0;
				TERM_RISE: if (was_s[ch] || !now_s[ch]) ok = 1'b0;
				TERM_FALL: if (!was_s[ch] || now_s[ch]) ok = 1'b0;
				default: ;
			endcase
		end
		return ok;
	endfunction

	// Advance the shadow state by one accepted sample and queue its match word.
	function automatic void predict_match(logic [SAMPLE_W-1:0] cur);
		match_t m;
		bit hit;
		hit = (active_count == 0);
		m.index = sample_no;
		m.mask = '0;
		for (int k = 0; k < NUM_CONDS; k++) begin
			if (k < active_count) begin
				if (skip_done[k] < skip_target[k])
					skip_done[k] = skip_done[k] + 1'b1;
				else if (cond_holds(cond_terms[k], cur, prev_sample)) begin
					m.mask[k] = 1'b1;
					hit = 1'b1;
				end
			end
		end
		if (hit)
			expected_matches.push_back(m);
		prev_sample = cur;
		sample_no = sample_no + 1'b1;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		bit listed;
		listed = 1'b1;
		case (idx) inside
			CFG_ACTIVE: active_count = data[ACTIVE_W-1:0];
			CFG_TERMS_A, CFG_TERMS_B, CFG_TERMS_C:
				cond_terms[2'(idx - CFG_TERMS_A)] = data;
			CFG_SKIP_A, CFG_SKIP_B, CFG_SKIP_C:
				skip_target[2'(idx - CFG_SKIP_A)] = data[SKIP_W-1:0];
			default: listed = 1'b0;
		endcase
		if (listed)
			for (int k = 0; k < NUM_CONDS; k++)
				skip_done[k] = '0;
	endfunction

	// Sample driver: presents queued samples, with a drawn gap after each word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_match(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (send_wait > 0) begin
					send_wait--;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= sample_q.pop_front();
					send_wait = draw_wait(send_idle);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each match word against the oldest expectation.
	always @(posedge clk) begin : result_monitor
		match_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("unexpected match word, index %0d",
						m_tdata[INDEX_W-1:0]));
				end else begin
					want = expected_matches.pop_front();
					if (m_tdata[INDEX_W-1:0] !== want.index)
						report_mismatch($sformatf("sample_index %0d, want %0d",
							m_tdata[INDEX_W-1:0], want.index));
					if (m_tdata[INDEX_W +: MASK_W] !== want.mask)
						report_mismatch($sformatf("match_mask %b at index %0d, want %b",
							m_tdata[INDEX_W +: MASK_W], want.index, want.mask));
					if (m_tdata[M_TDATA_W-1:INDEX_W+MASK_W] !== '0)
						report_mismatch($sformatf("nonzero fill bits at index %0d",
							want.index));
				end
				recv_wait = draw_wait(recv_idle);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !long_hold;
			end
		end
	end

	// Long receiver stall so that the output register fills and input backs up.
	initial begin
		wait (pressure_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Run-time limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic push_sample(logic [SAMPLE_W-1:0] value);
		sample_q.push_back(value);
		last_pushed = value;
	endtask

	// Wait until every sample is taken and every match word has come back.
	task automatic settle();
		do @(posedge clk);
		while (sample_q.size() != 0 || s_tvalid || expected_matches.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly sparse conditions so that matches are frequent; sometimes raw noise.
	function automatic logic [CFG_DATA_W-1:0] rand_terms();
		logic [63:0] r;
		logic [CFG_DATA_W-1:0] t;
		int ch;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return r[CFG_DATA_W-1:0];
			1: return '0;
			2: return '1;
			default: ;
		endcase
		t = '0;
		for (int c = 0; c < DEF_CHANNELS; c++)
			if ($urandom_range(0, 3) == 0)
				t[TERM_W*c +: TERM_W] = TERM_W'($urandom_range(5, 7));
		repeat ($urandom_range(0, 3)) begin
			ch = $urandom_range(0, DEF_CHANNELS - 1);
			t[TERM_W*ch +: TERM_W] = TERM_W'($urandom_range(TERM_HIGH, TERM_FALL));
		end
		return t;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_skip();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		case ($urandom_range(0, 7)) inside
			0: r[SKIP_W-1:0] = '1;
			1: r[SKIP_W-1:0] = $urandom();
			2, 3: r[SKIP_W-1:0] = '0;
			default: r[SKIP_W-1:0] = $urandom_range(1, 30);
		endcase
		return r[CFG_DATA_W-1:0];
	endfunction

	// Edge-rich sample sequence: small changes of the last word, extremes, noise.
	function automatic logic [SAMPLE_W-1:0] rand_sample(logic [SAMPLE_W-1:0] last);
		case ($urandom_range(0, 7)) inside
			0, 1: return SAMPLE_W'($urandom());
			2, 3: return last ^ (SAMPLE_W'(1) << $urandom_range(0, SAMPLE_W - 1));
			4: return last ^ (SAMPLE_W'($urandom()) & SAMPLE_W'($urandom()));
			5: return ($urandom_range(0, 1) != 0) ? '1 : '0;
			default: return last;
		endcase
	endfunction

	task automatic random_setup();
		logic [63:0] noise;
		noise = {$urandom(), $urandom()};
		if ($urandom_range(0, 4) == 0) begin
			write_reg(CFG_UNLISTED, noise[CFG_DATA_W-1:0]);
		end else begin
			for (int k = 0; k < NUM_CONDS; k++) begin
				if ($urandom_range(0, 1) != 0)
					write_reg(CFG_TERMS_A + CFG_IDX_W'(k), rand_terms());
				if ($urandom_range(0, 1) != 0)
					write_reg(CFG_SKIP_A + CFG_IDX_W'(k), rand_skip());
			end
			noise[ACTIVE_W-1:0] = ACTIVE_W'($urandom_range(0, 3));
			write_reg(CFG_ACTIVE, noise[CFG_DATA_W-1:0]);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge terms on the very first sample see an all-zero previous word;
		// codes five to seven act as don't-care.
		write_reg(CFG_TERMS_A, {16{TERM_RISE}});
		write_reg(CFG_TERMS_B, {16{TERM_FALL}});
		write_reg(CFG_TERMS_C, {4{3'd6, 3'd7, 3'd5, 3'd6}});
		write_reg(CFG_ACTIVE, 48'd3);
		push_sample(16'hFFFF);
		push_sample(16'hFFFF);
		push_sample(16'h0000);
		push_sample(16'hAAAA);
		push_sample(16'h5555);
		push_sample(16'h0000);
		settle();

		// Level terms, an all don't-care condition, and mixed edges.
		write_reg(CFG_TERMS_A, {8{TERM_LOW, TERM_HIGH}});
		write_reg(CFG_TERMS_B, '0);
		write_reg(CFG_TERMS_C, {8{TERM_FALL, TERM_RISE}});
		write_reg(CFG_ACTIVE, 48'd2);
		push_sample(16'h5555);
		push_sample(16'hAAAA);
		push_sample(16'h5555);
		settle();
		write_reg(CFG_ACTIVE, 48'd3);
		push_sample(16'hAAAA);
		push_sample(16'h5555);
		settle();

		// Skip phase; a write past the register list must not restart the count.
		write_reg(CFG_TERMS_A, '0);
		write_reg(CFG_SKIP_A, 48'hABCD_0000_0003);
		write_reg(CFG_ACTIVE, 48'hFFFF_FFFF_FFFD);
		push_sample(16'h0001);
		push_sample(16'h8000);
		settle();
		write_reg(CFG_UNLISTED, '1);
		push_sample(16'h7FFE);
		push_sample(16'hFFFF);
		settle();

		// No conditions: every sample matches with an empty mask.
		write_reg(CFG_SKIP_B, 48'd5);
		write_reg(CFG_ACTIVE, 48'd0);
		push_sample(16'h0000);
		push_sample(16'hFFFF);
		push_sample(16'h1234);
		settle();

		// Random phases with fresh settings between them.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			send_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
			recv_idle = (phase != 0) && ($urandom_range(0, 2) != 0);
			if (phase == PRESSURE_PHASE) begin
				send_idle = 1'b0;
				write_reg(CFG_ACTIVE, 48'd0);
				pressure_go = 1'b1;
			end else begin
				random_setup();
			end
			repeat (PHASE_ITEMS)
				push_sample(rand_sample(last_pushed));
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_matches.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/scm_pkg.sv
design/scm_lane.sv
design/scm_merge.sv
design/sample_condition_matcher_core.sv
tb/testbench.sv
